FILE: rtl/csft_pkg.sv
// csft_pkg: shared types, constants and sine functions for the cycloid swing-foot block
// no dependencies
`timescale 1ns / 1ps
package csft_pkg;
  localparam int unsigned PosW = 24;
  localparam int unsigned VelW = 32;
  localparam int unsigned CfgW = 32;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CfgStepHeight = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgInvSwing = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgInvSwingSq = 2'd2;

  localparam logic signed [25:0] KInv2PiQ24 = 26'sd2670177;
  localparam logic signed [18:0] KPiQ16 = 19'sd205887;
  localparam logic signed [19:0] K2PiQ16 = 20'sd411775;
  localparam logic signed [21:0] K2Pi2Q16 = 22'sd1293629;

  localparam logic [63:0] C1 = 64'd1686629713;
  localparam logic [63:0] C3 = 64'd693598668;
  localparam logic [63:0] C5 = 64'd85569306;
  localparam logic [63:0] C7 = 64'd5026995;
  localparam logic [63:0] C9 = 64'd172272;
  localparam logic [63:0] C11 = 64'd3864;

  // sin(pi/2*u), u in q30; used at elaboration only to fill the table
  function automatic logic [63:0] quarter_sin(input logic [63:0] u);
    logic [63:0] u2, p3, p5, p7, p9, p11, s;
    u2 = (u * u) >> 30;
    p3 = (u * u2) >> 30;
    p5 = (p3 * u2) >> 30;
    p7 = (p5 * u2) >> 30;
    p9 = (p7 * u2) >> 30;
    p11 = (p9 * u2) >> 30;
    s = (C1 * u) >> 30;
    s = s - ((C3 * p3) >> 30);
    s = s + ((C5 * p5) >> 30);
    s = s - ((C7 * p7) >> 30);
    s = s + ((C9 * p9) >> 30);
    s = s - ((C11 * p11) >> 30);
    return s;
  endfunction

  // sine of a q0.32 turn in q1.16
  function automatic logic signed [17:0] sin_turn(input logic [31:0] t);
    logic [1:0] q;
    logic [63:0] r, u, v;
    q = t[31:30];
    r = {34'd0, t[29:0]};
    u = q[0] ? (64'h4000_0000 - r) : r;
    v = (quarter_sin(u) + 64'd8192) >> 14;
    return q[1] ? -$signed(v[17:0]) : $signed(v[17:0]);
  endfunction

  typedef struct packed {
    logic signed [PosW-1:0] x;
    logic signed [PosW-1:0] y;
    logic signed [PosW-1:0] z;
  } vec_t;
endpackage

FILE: rtl/cycloid_swing_foot_trajectory_top.sv
// cycloid_swing_foot_trajectory_top: per-foot cycloid swing trajectory generator
// depends on csft_pkg
//
// usage:
//   s_axis carries one request per transaction; tuser marks a restart, otherwise
//   tdata is a foot update with contact flag, phase, measured position and
//   landing target. m_axis returns one result per valid foot update (position,
//   velocity, acceleration). restart and out-of-range feet give no result.
//   cfg_we_i/cfg_idx_i/cfg_data_i write the three registers while idle.
// sequence:
//   a foot update passes through three read/modify steps on the start point
//   memory (SRead then SLoad for each word), the registered multiply steps
//   SM1 to SM3, a further step SM4 and the output step SOut. the next item is
//   taken only once the sequencer is back in idle; a restart is handled in
//   the idle state without leaving it.
// start points live in a synchronous ram (NUM_FEET*3 words); loaded flags
// are flip-flops cleared by reset and by restart.
// reset: all control state clears, registers take their defaults.
// stall: the result waits in the output register while the next item is
// taken and computed; the sequencer holds in its output step until the
// output register is free.
`timescale 1ns / 1ps
module cycloid_swing_foot_trajectory_top
  import csft_pkg::*;
#(
  parameter int unsigned NUM_FEET = 4,
  parameter int unsigned PHASE_BITS = 16,
  parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // foot[1:0], in_contact[2], phase[18:3], meas_x, meas_y, meas_z,
  // target_x, target_y (24 bits each from bit 19), zero pad to 144
  input  logic [143:0]  s_axis_tdata,
  // req_type[0]
  input  logic          s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // pos_x[23:0] pos_y[47:24] pos_z[71:48] vel_x vel_y vel_z acc_x acc_y
  // acc_z (32 bits each from bit 72)
  output logic [263:0]  m_axis_tdata,
  input  logic          cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i
);
  localparam int unsigned FootW = (NUM_FEET > 1) ? $clog2(NUM_FEET) : 1;
  localparam int unsigned TabW = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned Depth = NUM_FEET * 3;
  localparam int unsigned AddrW = $clog2(Depth);

  typedef enum logic [3:0] {
    SIdle, SRead, SLoad, SM1, SM2, SM3, SM4, SOut
  } state_e;

  function automatic logic signed [63:0] rsh(input logic signed [63:0] x, input int n);
    logic [63:0] a;
    a = x[63] ? -x : x;
    a = (a + (64'd1 << (n - 1))) >> n;
    return x[63] ? -$signed(a) : $signed(a);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [63:0] x);
    if (x > 64'sd8388607) return 24'sh7fffff;
    if (x < -64'sd8388608) return 24'sh800000;
    return x[23:0];
  endfunction

  function automatic logic signed [17:0] tab_sin(input logic [TabW-1:0] k);
    logic [63:0] t;
    t = ({32'd0, {(32-TabW){1'b0}}, k} << 32) / SINE_TABLE_DEPTH;
    return sin_turn(t[31:0]);
  endfunction

  logic signed [17:0] sin_tab [SINE_TABLE_DEPTH];
  for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_tab
    assign sin_tab[g] = tab_sin(TabW'(g));
  end

  logic [22:0] step_height_q;
  logic [23:0] inv_swing_q;
  logic [31:0] inv_swing_sq_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_height_q <= 23'd5243;
      inv_swing_q <= 24'd327680;
      inv_swing_sq_q <= 32'd1638400;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgStepHeight: step_height_q <= cfg_data_i[22:0];
        CfgInvSwing: inv_swing_q <= cfg_data_i[23:0];
        CfgInvSwingSq: inv_swing_sq_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // start point memory: one vec per foot stored as three words
  logic [PosW-1:0] sp_mem [Depth];
  logic [1:0] ax_q;
  logic sp_we;
  logic [AddrW-1:0] sp_waddr, sp_raddr;
  logic [PosW-1:0] sp_wdata, sp_rdata_q;
  always_ff @(posedge clk_i) begin
    if (sp_we) sp_mem[sp_waddr] <= sp_wdata;
    sp_rdata_q <= sp_mem[sp_raddr];
  end

  state_e state_q;
  logic [NUM_FEET-1:0] loaded_q;
  logic [143:0] req_q;
  logic [FootW-1:0] foot_q;
  logic contact_q, reload_q;
  logic [PHASE_BITS-1:0] ph_q;
  vec_t sp_q;
  logic signed [17:0] s_q, c_q;
  logic signed [33:0] f_q;
  logic signed [63:0] t_q [9];
  logic signed [63:0] u_q [3:8];
  logic [263:0] out_q;
  logic out_v_q;
  logic out_load;

  logic [1:0] foot_in;
  logic [PHASE_BITS-1:0] ph_in;
  assign foot_in = s_axis_tdata[1:0];
  assign ph_in = PHASE_BITS'(s_axis_tdata[18:3]);

  logic signed [PosW-1:0] meas [3];
  assign meas[0] = req_q[42:19];
  assign meas[1] = req_q[66:43];
  assign meas[2] = req_q[90:67];
  logic signed [PosW-1:0] tgt [2];
  assign tgt[0] = req_q[114:91];
  assign tgt[1] = req_q[138:115];

  assign sp_raddr = AddrW'(foot_q * 3 + ax_q);
  assign sp_waddr = sp_raddr;
  assign sp_we = (state_q == SRead) && reload_q;
  always_comb begin
    unique case (ax_q)
      2'd0: sp_wdata = meas[0];
      2'd1: sp_wdata = meas[1];
      default: sp_wdata = meas[2];
    endcase
  end

  logic [TabW-1:0] k;
  assign k = TabW'((64'(ph_q) * SINE_TABLE_DEPTH) >> PHASE_BITS);

  assign s_axis_tready = (state_q == SIdle);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = out_q;
  assign out_load = (state_q == SOut) && (!out_v_q || m_axis_tready);

  logic signed [24:0] d [2];
  logic signed [18:0] omc;
  logic signed [23:0] h;
  logic signed [24:0] inv_s;
  logic signed [32:0] inv_sq_s;
  assign d[0] = 25'(tgt[0]) - 25'(sp_q.x);
  assign d[1] = 25'(tgt[1]) - 25'(sp_q.y);
  assign omc = 19'sd65536 - 19'(c_q);
  assign h = $signed({1'b0, step_height_q});
  assign inv_s = $signed({1'b0, inv_swing_q});
  assign inv_sq_s = $signed({1'b0, inv_swing_sq_q});

  // rounded products brought back to 32 bits before the next multiply
  logic signed [31:0] tr [3:8];
  logic signed [31:0] ur [5:8];
  always_comb begin
    for (int i = 3; i < 9; i++) tr[i] = 32'(rsh(t_q[i], 16));
    for (int i = 5; i < 9; i++) ur[i] = 32'(rsh(u_q[i], 16));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      loaded_q <= '0;
      out_v_q <= 1'b0;
      ax_q <= '0;
    end else begin
      if (out_load) out_v_q <= 1'b1;
      else if (m_axis_tready) out_v_q <= 1'b0;
      unique case (state_q)
        SIdle: if (s_axis_tvalid && s_axis_tready) begin
          req_q <= s_axis_tdata;
          if (s_axis_tuser) begin
            loaded_q <= '0;
          end else if (32'(foot_in) < NUM_FEET) begin
            foot_q <= FootW'(foot_in);
            contact_q <= s_axis_tdata[2];
            ph_q <= ph_in;
            reload_q <= !loaded_q[foot_in] ||
              (s_axis_tdata[2] && !ph_in[PHASE_BITS-1]);
            ax_q <= '0;
            state_q <= SRead;
          end
        end
        SRead: begin
          if (reload_q) begin
            unique case (ax_q)
              2'd0: sp_q.x <= meas[0];
              2'd1: sp_q.y <= meas[1];
              default: sp_q.z <= meas[2];
            endcase
          end
          state_q <= SLoad;
        end
        SLoad: begin
          // read data for ax_q is valid now
          if (!reload_q) begin
            unique case (ax_q)
              2'd0: sp_q.x <= sp_rdata_q;
              2'd1: sp_q.y <= sp_rdata_q;
              default: sp_q.z <= sp_rdata_q;
            endcase
          end
          if (ax_q == 2'd2) begin
            loaded_q[foot_q] <= 1'b1;
            s_q <= sin_tab[k];
            c_q <= sin_tab[TabW'(k + TabW'(SINE_TABLE_DEPTH / 4))];
            state_q <= SM1;
          end else begin
            ax_q <= ax_q + 2'd1;
            state_q <= SRead;
          end
        end
        SM1: begin
          f_q <= 34'(64'({ph_q, {(32-PHASE_BITS){1'b0}}}) -
                     rsh(64'(s_q * KInv2PiQ24), 8));
          t_q[3] <= d[0] * omc;
          t_q[4] <= d[1] * omc;
          t_q[5] <= h * s_q;
          t_q[6] <= d[0] * s_q;
          t_q[7] <= d[1] * s_q;
          t_q[8] <= h * c_q;
          t_q[2] <= h * omc;
          state_q <= SM2;
        end
        SM2: begin
          t_q[0] <= d[0] * f_q;
          t_q[1] <= d[1] * f_q;
          u_q[5] <= tr[5] * KPiQ16;
          u_q[6] <= tr[6] * K2PiQ16;
          u_q[7] <= tr[7] * K2PiQ16;
          u_q[8] <= tr[8] * K2Pi2Q16;
          state_q <= SM3;
        end
        SM3: begin
          u_q[3] <= tr[3] * inv_s;
          u_q[4] <= tr[4] * inv_s;
          u_q[5] <= ur[5] * inv_s;
          u_q[6] <= ur[6] * inv_sq_s;
          u_q[7] <= ur[7] * inv_sq_s;
          u_q[8] <= ur[8] * inv_sq_s;
          state_q <= SM4;
        end
        SM4: state_q <= SOut;
        SOut: if (out_load) begin
          if (contact_q) begin
            out_q <= {192'd0, sp_q.z, sp_q.y, sp_q.x};
          end else begin
            out_q <= {sat32(rsh(u_q[8], 16)), sat32(rsh(u_q[7], 16)),
                      sat32(rsh(u_q[6], 16)), sat32(rsh(u_q[5], 16)),
                      sat32(rsh(u_q[4], 16)), sat32(rsh(u_q[3], 16)),
                      sat24(64'(sp_q.z) + rsh(t_q[2], 17)),
                      sat24(64'(sp_q.y) + rsh(t_q[1], 32)),
                      sat24(64'(sp_q.x) + rsh(t_q[0], 32))};
          end
          state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end
endmodule

FILE: rtl/csft_checker.sv
// csft_checker: port-level assertions for the cycloid swing-foot block
// no package dependencies; bound into cycloid_swing_foot_trajectory_top
`timescale 1ns / 1ps
module csft_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic s_axis_tuser,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [263:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped under stall");
  a_restart_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("restart gave result");
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result valid out of reset");
  a_ctrl_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({s_axis_tready, m_axis_tvalid}))
    else $error("handshake output unknown");
endmodule

bind cycloid_swing_foot_trajectory_top csft_checker u_csft_checker (.*);
